/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property that must hold at every clock edge outside reset.
`define SLB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("status sequencer check failed");

// Checks that a condition seen at one edge leads to a consequence at the next edge.
`define SLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("status sequencer check failed");

`endif

/* hw/rtl/slbps_pkg.sv */
`default_nettype none

package slbps_pkg;

    localparam int QUEUE_SLOTS = 3;
    localparam int EV_W        = 3;
    localparam int CNT_W       = 8;
    localparam int HZ_W        = 13;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Input operations.
    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_ADD       = 2'd1,
        OP_START_END = 2'd2
    } op_t;

    // Event codes held in the queue.
    localparam logic [EV_W-1:0] EV_NONE  = 3'd0;
    localparam logic [EV_W-1:0] EV_CMD   = 3'd1;
    localparam logic [EV_W-1:0] EV_USB   = 3'd2;
    localparam logic [EV_W-1:0] EV_ABORT = 3'd3;
    localparam logic [EV_W-1:0] EV_ERROR = 3'd4;

    // Mission states.
    localparam logic [2:0] MS_STARTUP   = 3'd0;
    localparam logic [2:0] MS_NAV_START = 3'd1;
    localparam logic [2:0] MS_GND_LOCK  = 3'd2;
    localparam logic [2:0] MS_PAD_IDLE  = 3'd3;
    localparam logic [2:0] MS_CHUTE     = 3'd4;
    localparam logic [2:0] MS_LANDED    = 3'd5;
    localparam logic [2:0] MS_START_FAIL = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INDICATOR_EN = 2'd0;
    localparam logic [1:0] CFG_BUZZER_EN    = 2'd1;
    localparam logic [1:0] CFG_LED_EN       = 2'd2;

    // LED levels: bit 2 red, bit 1 green, bit 0 blue; a low pin is lit.
    localparam logic [2:0] LED_ALL_OFF = 3'b111;

    typedef logic [QUEUE_SLOTS-1:0][EV_W-1:0] slots_t;

    // Requests from the top level to the event queue.
    typedef struct packed {
        logic            add;
        logic            tick;
        logic            pop;
        logic [EV_W-1:0] ev;
    } q_req_t;

    // Queue status toward the top level and the pattern logic.
    typedef struct packed {
        logic            busy;
        logic [EV_W-1:0] play_head;
        logic [EV_W-1:0] head;
        logic            dropped;
        logic            to_head;
    } q_stat_t;

    // What the pattern for this tick writes.
    typedef struct packed {
        logic            led_wr;
        logic [2:0]      led_val;
        logic            tone_wr;
        logic            tone_on;
        logic [HZ_W-1:0] tone_hz;
        logic            finish;
        logic            startup_set;
    } pat_action_t;

    function automatic logic in_win(input logic [CNT_W-1:0] c,
                                    input logic [CNT_W-1:0] lo,
                                    input logic [CNT_W-1:0] hi);
        return (c > lo) && (c <= hi);
    endfunction

    // One compaction pass from the head: an empty slot pulls in its successor.
    function automatic slots_t compact_slots(input slots_t s);
        slots_t r;
        r = s;
        for (int i = 0; i < QUEUE_SLOTS - 1; i++) begin
            if (r[i] == EV_NONE) begin
                r[i]   = r[i+1];
                r[i+1] = EV_NONE;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/slbps_pattern.sv */
`default_nettype none

module slbps_pattern
    import slbps_pkg::*;
(
    input  wire logic             use_event,
    input  wire logic [EV_W-1:0]  event_code,
    input  wire logic [2:0]       mission_state,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic             startup_done,
    output pat_action_t           action
);

    always_comb
    begin
        action = '0;
        if (use_event)
        begin
            case (event_code)
                EV_CMD:
                begin
                    if (in_win(count, 8'd0, 8'd2) || in_win(count, 8'd4, 8'd6))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd3100;
                        action.led_wr = 1'b1; action.led_val = 3'b000;
                    end
                    else if (in_win(count, 8'd2, 8'd4) || in_win(count, 8'd6, 8'd8))
                    begin
                        action.tone_wr = 1'b1;
                        action.led_wr = 1'b1; action.led_val = LED_ALL_OFF;
                    end
                    else if (in_win(count, 8'd8, 8'd10))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd3100;
                        action.led_wr = 1'b1; action.led_val = 3'b010;
                    end
                    else if (count >= 8'd12)
                    begin
                        action.finish = 1'b1;
                    end
                end
                EV_USB:
                begin
                    if (in_win(count, 8'd0, 8'd7))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd2600;
                        action.led_wr = 1'b1; action.led_val = 3'b001;
                    end
                    else if (in_win(count, 8'd7, 8'd11))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd3100;
                        action.led_wr = 1'b1; action.led_val = 3'b000;
                    end
                    else if (count >= 8'd11)
                    begin
                        action.finish = 1'b1;
                    end
                end
                EV_ABORT:
                begin
                    if (in_win(count, 8'd0, 8'd11))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd3500;
                        action.led_wr = 1'b1; action.led_val = 3'b011;
                    end
                    else if (count >= 8'd11)
                    begin
                        action.finish = 1'b1;
                    end
                end
                EV_ERROR:
                begin
                    if (in_win(count, 8'd0, 8'd7))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd3300;
                        action.led_wr = 1'b1; action.led_val = 3'b011;
                    end
                    else if (in_win(count, 8'd7, 8'd11))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd3700;
                        action.led_wr = 1'b1; action.led_val = 3'b100;
                    end
                    else if (count >= 8'd11)
                    begin
                        action.finish = 1'b1;
                    end
                end
                default:
                begin
                    action = '0;
                end
            endcase
        end
        else
        begin
            case (mission_state)
                MS_STARTUP:
                begin
                    if (!startup_done)
                    begin
                        if (in_win(count, 8'd8, 8'd12))
                        begin
                            action.led_wr = 1'b1; action.led_val = 3'b011;
                            action.tone_wr = 1'b1; action.tone_on = 1'b1;
                            action.tone_hz = 13'd2000;
                        end
                        else if (in_win(count, 8'd12, 8'd18))
                        begin
                            action.tone_wr = 1'b1; action.tone_on = 1'b1;
                            action.tone_hz = 13'd2200;
                        end
                        else if (in_win(count, 8'd16, 8'd30))
                        begin
                            action.tone_wr = 1'b1; action.tone_on = 1'b1;
                            action.tone_hz = 13'd2550;
                        end
                        else if (count >= 8'd30)
                        begin
                            action.startup_set = 1'b1;
                            action.finish = 1'b1;
                        end
                    end
                end
                MS_NAV_START:
                begin
                    if (in_win(count, 8'd8, 8'd14))
                    begin
                        action.led_wr = 1'b1; action.led_val = 3'b110;
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd2300;
                    end
                    else if (in_win(count, 8'd14, 8'd18))
                    begin
                        action.tone_wr = 1'b1;
                    end
                    else if (in_win(count, 8'd18, 8'd30))
                    begin
                        action.led_wr = 1'b1; action.led_val = 3'b000;
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd2400;
                    end
                    else if (count >= 8'd30)
                    begin
                        action.finish = 1'b1;
                    end
                end
                MS_GND_LOCK:
                begin
                    if (in_win(count, 8'd9, 8'd16))
                    begin
                        action.led_wr = 1'b1; action.led_val = 3'b000;
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd3400;
                    end
                    else if (in_win(count, 8'd15, 8'd18))
                    begin
                        action.led_wr = 1'b1; action.led_val = 3'b010;
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd3200;
                    end
                    else if (in_win(count, 8'd17, 8'd20))
                    begin
                        action.led_wr = 1'b1; action.led_val = LED_ALL_OFF;
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd3600;
                    end
                    else if (count >= 8'd20)
                    begin
                        action.finish = 1'b1;
                    end
                end
                MS_PAD_IDLE:
                begin
                    if (in_win(count, 8'd9, 8'd16))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd1800;
                        action.led_wr = 1'b1; action.led_val = 3'b100;
                    end
                    else if (in_win(count, 8'd16, 8'd100))
                    begin
                        action.finish = 1'b1;
                    end
                end
                MS_CHUTE:
                begin
                    if (in_win(count, 8'd4, 8'd11))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd2800;
                        action.led_wr = 1'b1; action.led_val = 3'b110;
                    end
                    else if (in_win(count, 8'd9, 8'd100))
                    begin
                        action.finish = 1'b1;
                    end
                end
                MS_LANDED:
                begin
                    if (in_win(count, 8'd4, 8'd20))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd3000;
                        action.led_wr = 1'b1; action.led_val = 3'b010;
                    end
                    else if (in_win(count, 8'd19, 8'd44))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd3600;
                        action.led_wr = 1'b1; action.led_val = 3'b101;
                    end
                    else if (count >= 8'd43)
                    begin
                        action.finish = 1'b1;
                    end
                end
                MS_START_FAIL:
                begin
                    if (in_win(count, 8'd9, 8'd21))
                    begin
                        action.tone_wr = 1'b1; action.tone_on = 1'b1;
                        action.tone_hz = 13'd5000;
                        action.led_wr = 1'b1; action.led_val = 3'b011;
                    end
                    else if (in_win(count, 8'd20, 8'd100))
                    begin
                        action.finish = 1'b1;
                    end
                end
                default:
                begin
                    action = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/slbps_queue.sv */
`default_nettype none

module slbps_queue
    import slbps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  q_req_t    req,
    output q_stat_t   stat
);

    slots_t slots_reg;
    slots_t slots_next;
    slots_t packed_slots;
    slots_t popped_slots;
    logic   found;

    // The compacted view is what a tick plays from and what an add stores into.
    assign packed_slots = compact_slots(slots_reg);

    always_comb
    begin
        popped_slots    = packed_slots;
        popped_slots[0] = EV_NONE;
        popped_slots    = compact_slots(popped_slots);
    end

    always_comb
    begin
        slots_next     = slots_reg;
        found          = 1'b0;
        stat.busy      = (slots_reg != '0);
        stat.play_head = packed_slots[0];
        stat.head      = slots_reg[0];
        stat.dropped   = 1'b0;
        stat.to_head   = 1'b0;
        if (req.add)
        begin
            slots_next = packed_slots;
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                if (!found && packed_slots[i] == EV_NONE)
                begin
                    slots_next[i] = req.ev;
                    found = 1'b1;
                    if (i == 0)
                    begin
                        stat.to_head = 1'b1;
                    end
                end
            end
            stat.dropped = !found;
        end
        else if (req.tick)
        begin
            slots_next = req.pop ? popped_slots : packed_slots;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= '0;
        end
        else
        begin
            slots_reg <= slots_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/status_led_buzzer_pattern_sequencer_top.sv */
// A result appears in the cycle after its input transfer and shows the state after it.
// Throughput: one item per cycle unless a result is stalled; the single result register
// decouples the two channels. The input is ready whenever the result register is empty or
// being taken in that cycle. Reset clears the queue, counter, startup flag, LED levels
// (all lit) and tone, and sets all three enables; no clearing pass is needed.
`default_nettype none

module status_led_buzzer_pattern_sequencer_top
    import slbps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Item channel.
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [2:0]  event_code,
    input  wire logic [2:0]  mission_state,
    // Result channel.
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             led_red,
    output logic             led_green,
    output logic             led_blue,
    output logic             buzzer_on,
    output logic [12:0]      buzzer_freq,
    output logic [2:0]       head_event,
    output logic             event_dropped,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic        cfg_data
);

    // Configuration registers. Writes are always taken, as cfg_ready is tied high.
    logic indicator_en_reg;
    logic buzzer_en_reg;
    logic led_en_reg;

    // Sequencer state. The LED and tone registers double as the result payload,
    // since the output always shows the state left by the last transfer.
    logic [CNT_W-1:0] count_reg,   count_next;
    logic             startup_reg, startup_next;
    logic [2:0]       led_reg,     led_next;
    logic [HZ_W-1:0]  freq_reg,    freq_next;
    logic             tone_reg,    tone_next;
    logic             dropped_reg, dropped_next;
    logic             out_valid_reg, out_valid_next;

    logic             accept;
    op_t              op;
    logic             tick;
    logic             add_ok;
    logic [CNT_W-1:0] count_inc;
    q_req_t           q_req;
    q_stat_t          q_stat;
    pat_action_t      action;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign op        = op_t'(opcode);

    // A tick only counts when the indicator is enabled; otherwise it is a no-op.
    assign tick   = accept && (op == OP_TICK) && indicator_en_reg;
    assign add_ok = accept && (op == OP_ADD) && (event_code inside {[EV_CMD:EV_ERROR]});

    // The counter saturates so that long idle stretches never wrap into a window.
    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;

    assign q_req.add  = add_ok;
    assign q_req.tick = tick;
    assign q_req.pop  = q_stat.busy && action.finish;
    assign q_req.ev   = event_code;

    slbps_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (q_req),
        .stat  (q_stat)
    );

    // Event patterns take priority over the mission pattern while anything is queued.
    slbps_pattern u_pattern
    (
        .use_event     (q_stat.busy),
        .event_code    (q_stat.play_head),
        .mission_state (mission_state),
        .count         (count_inc),
        .startup_done  (startup_reg),
        .action        (action)
    );

    always_comb
    begin
        count_next   = count_reg;
        startup_next = startup_reg;
        led_next     = led_reg;
        freq_next    = freq_reg;
        tone_next    = tone_reg;
        dropped_next = dropped_reg;

        if (accept)
        begin
            dropped_next = 1'b0;
        end

        if (tick)
        begin
            count_next = count_inc;
            if (action.led_wr)
            begin
                led_next = led_en_reg ? action.led_val : LED_ALL_OFF;
            end
            if (action.tone_wr)
            begin
                if (buzzer_en_reg && action.tone_on)
                begin
                    freq_next = action.tone_hz;
                    tone_next = 1'b1;
                end
                else
                begin
                    freq_next = '0;
                    tone_next = 1'b0;
                end
            end
            // A finished pattern clears the counter and turns everything off.
            if (action.finish)
            begin
                count_next = '0;
                led_next   = LED_ALL_OFF;
                freq_next  = '0;
                tone_next  = 1'b0;
            end
            if (action.startup_set)
            begin
                startup_next = 1'b1;
            end
        end
        else if (add_ok)
        begin
            dropped_next = q_stat.dropped;
            // A new head event restarts its pattern from the beginning.
            if (q_stat.to_head)
            begin
                count_next = '0;
            end
        end
        else if (accept && (op == OP_START_END))
        begin
            startup_next = 1'b1;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            indicator_en_reg <= 1'b1;
            buzzer_en_reg    <= 1'b1;
            led_en_reg       <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INDICATOR_EN: indicator_en_reg <= cfg_data;
                CFG_BUZZER_EN:    buzzer_en_reg    <= cfg_data;
                CFG_LED_EN:       led_en_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            startup_reg   <= 1'b0;
            led_reg       <= '0;
            freq_reg      <= '0;
            tone_reg      <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            startup_reg   <= startup_next;
            led_reg       <= led_next;
            freq_reg      <= freq_next;
            tone_reg      <= tone_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign led_red       = led_reg[2];
    assign led_green     = led_reg[1];
    assign led_blue      = led_reg[0];
    assign buzzer_on     = tone_reg;
    assign buzzer_freq   = freq_reg;
    assign head_event    = q_stat.head;
    assign event_dropped = dropped_reg;

endmodule

`default_nettype wire

/* hw/rtl/slbps_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module slbps_checker
    import slbps_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  opcode,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        led_red,
    input wire logic        led_green,
    input wire logic        led_blue,
    input wire logic        buzzer_on,
    input wire logic [12:0] buzzer_freq,
    input wire logic [2:0]  head_event,
    input wire logic        event_dropped
);

    // A stalled result keeps its payload.
    `SLB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable({led_red, led_green, led_blue, buzzer_on, buzzer_freq,
                              head_event, event_dropped}))

    // Every input transfer yields a result on the next cycle.
    `SLB_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)

    // A sounding buzzer always carries a nonzero frequency, and a silent one carries zero.
    `SLB_ASSERT(a_tone_consistent, buzzer_on == (buzzer_freq != 13'd0))

    // Only an add can report a full queue.
    `SLB_ASSERT_NEXT(a_drop_only_add, in_valid && in_ready && (opcode != OP_ADD),
        !event_dropped)

    // A full queue always has an event at its head.
    `SLB_ASSERT(a_drop_head, !(out_valid && event_dropped) || (head_event != EV_NONE))

endmodule

bind status_led_buzzer_pattern_sequencer_top slbps_checker u_slbps_checker (.*);

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

// Testbench for the status LED and buzzer pattern sequencer.
//
// A reference of the sequencer runs inside this module. It holds its own copy of the
// event queue, the pattern counter, the startup flag, the LED levels, the tone and
// the three enable registers. Each item transfer on the input channel advances that
// copy, and the status it predicts is queued. Each result transfer is checked field
// by field against the oldest queued status.
//
// Both channels idle at random. Gaps before input transfers and stalls on the result
// channel are mostly short with a few long ones. The quiet flag switches both off for
// some stretches so that back-to-back traffic is covered as well.
module tb;
    import slbps_pkg::*;

    // Opcode 3 has no meaning. The block must leave every piece of state alone.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Mission state 7 means that no mission pattern is selected.
    localparam logic [2:0] MS_NONE = 3'd7;
    // Event codes above the error code are not events and must be ignored.
    localparam logic [EV_W-1:0] EV_BAD_MIN = 3'd5;
    localparam logic [EV_W-1:0] EV_BAD_MAX = 3'd7;

    // One result of the block, which is the status after one item.
    typedef struct {
        logic            red;
        logic            green;
        logic            blue;
        logic            tone_on;
        logic [HZ_W-1:0] hz;
        logic [EV_W-1:0] head;
        logic            dropped;
    } status_t;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic [1:0]      opcode;
    logic [2:0]      event_code;
    logic [2:0]      mission_state;
    logic            out_valid;
    logic            out_ready;
    logic            led_red;
    logic            led_green;
    logic            led_blue;
    logic            buzzer_on;
    logic [12:0]     buzzer_freq;
    logic [2:0]      head_event;
    logic            event_dropped;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [1:0]      cfg_index;
    logic            cfg_data;

    // Status values that the block still owes, oldest first.
    status_t pending_status[$];
    int      mismatches = 0;
    // When set, neither side inserts gaps or stalls.
    bit      quiet = 1'b0;

    // Private copy of the sequencer state.
    logic [EV_W-1:0]  ev_slot [QUEUE_SLOTS];
    logic [CNT_W-1:0] pat_cnt;
    bit               startup_seen;
    logic [2:0]       led_lvl;
    logic [HZ_W-1:0]  tone_hz;
    logic             tone_live;
    bit               en_ind;
    bit               en_buz;
    bit               en_led;

    status_led_buzzer_pattern_sequencer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .event_code    (event_code),
        .mission_state (mission_state),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .led_red       (led_red),
        .led_green     (led_green),
        .led_blue      (led_blue),
        .buzzer_on     (buzzer_on),
        .buzzer_freq   (buzzer_freq),
        .head_event    (head_event),
        .event_dropped (event_dropped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Status prediction
    // ------------------------------------------------------------------------

    function automatic void reset_indicator();
        foreach (ev_slot[i])
        begin
            ev_slot[i] = EV_NONE;
        end
        pat_cnt      = '0;
        startup_seen = 1'b0;
        led_lvl      = '0;
        tone_hz      = '0;
        tone_live    = 1'b0;
        en_ind       = 1'b1;
        en_buz       = 1'b1;
        en_led       = 1'b1;
    endfunction

    // A window is open for counts above lo up to and including hi.
    function automatic bit in_span(input int c, input int lo, input int hi);
        return (c > lo) && (c <= hi);
    endfunction

    // The buzzer enable is applied when a tone is written, not afterwards.
    function automatic void drive_tone(input int hz, input bit on);
        if (!en_buz || !on)
        begin
            tone_hz   = '0;
            tone_live = 1'b0;
        end
        else
        begin
            tone_hz   = hz[HZ_W-1:0];
            tone_live = 1'b1;
        end
    endfunction

    // Likewise the LED enable only matters at the moment the LED is written.
    function automatic void drive_led(input bit r, input bit g, input bit b);
        if (!en_led)
            led_lvl = LED_ALL_OFF;
        else
            led_lvl = {r, g, b};
    endfunction

    // Single pass from the head: an empty slot takes the contents of its successor.
    function automatic void shift_slots();
        for (int i = 0; i < QUEUE_SLOTS - 1; i++)
        begin
            if (ev_slot[i] == EV_NONE)
            begin
                ev_slot[i]   = ev_slot[i+1];
                ev_slot[i+1] = EV_NONE;
            end
        end
    endfunction

    function automatic bit queue_empty();
        foreach (ev_slot[i])
        begin
            if (ev_slot[i] != EV_NONE)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Checking for queued events also compacts the queue when it finds one.
    function automatic bit events_pending();
        if (queue_empty())
            return 1'b0;
        shift_slots();
        return 1'b1;
    endfunction

    function automatic void go_dark();
        pat_cnt = '0;
        drive_tone(0, 1'b0);
        drive_led(1'b1, 1'b1, 1'b1);
    endfunction

    function automatic void retire_head();
        ev_slot[0] = EV_NONE;
        shift_slots();
        go_dark();
    endfunction

    function automatic void play_event_pattern(input logic [EV_W-1:0] ev, input int c);
        case (ev)
            EV_CMD:
            begin
                if (in_span(c, 0, 2) || in_span(c, 4, 6))
                begin
                    drive_tone(3100, 1'b1);
                    drive_led(1'b0, 1'b0, 1'b0);
                end
                else if (in_span(c, 2, 4) || in_span(c, 6, 8))
                begin
                    drive_tone(0, 1'b0);
                    drive_led(1'b1, 1'b1, 1'b1);
                end
                else if (in_span(c, 8, 10))
                begin
                    drive_tone(3100, 1'b1);
                    drive_led(1'b0, 1'b1, 1'b0);
                end
                else if (c >= 12)
                    retire_head();
            end
            EV_USB:
            begin
                if (in_span(c, 0, 7))
                begin
                    drive_tone(2600, 1'b1);
                    drive_led(1'b0, 1'b0, 1'b1);
                end
                else if (in_span(c, 7, 11))
                begin
                    drive_tone(3100, 1'b1);
                    drive_led(1'b0, 1'b0, 1'b0);
                end
                else if (c >= 11)
                    retire_head();
            end
            EV_ABORT:
            begin
                if (in_span(c, 0, 11))
                begin
                    drive_tone(3500, 1'b1);
                    drive_led(1'b0, 1'b1, 1'b1);
                end
                else if (c >= 11)
                    retire_head();
            end
            EV_ERROR:
            begin
                if (in_span(c, 0, 7))
                begin
                    drive_tone(3300, 1'b1);
                    drive_led(1'b0, 1'b1, 1'b1);
                end
                else if (in_span(c, 7, 11))
                begin
                    drive_tone(3700, 1'b1);
                    drive_led(1'b1, 1'b0, 1'b0);
                end
                else if (c >= 11)
                    retire_head();
            end
            default:
            begin
            end
        endcase
    endfunction

    // Some windows overlap. The first matching branch wins, in the order written.
    function automatic void play_mission_pattern(input logic [2:0] st, input int c);
        case (st)
            MS_STARTUP:
            begin
                if (!startup_seen)
                begin
                    if (in_span(c, 8, 12))
                    begin
                        drive_led(1'b0, 1'b1, 1'b1);
                        drive_tone(2000, 1'b1);
                    end
                    else if (in_span(c, 12, 18))
                        drive_tone(2200, 1'b1);
                    else if (in_span(c, 16, 30))
                        drive_tone(2550, 1'b1);
                    else if (c >= 30)
                    begin
                        startup_seen = 1'b1;
                        go_dark();
                    end
                end
            end
            MS_NAV_START:
            begin
                if (in_span(c, 8, 14))
                begin
                    drive_led(1'b1, 1'b1, 1'b0);
                    drive_tone(2300, 1'b1);
                end
                else if (in_span(c, 14, 18))
                    drive_tone(0, 1'b0);
                else if (in_span(c, 18, 30))
                begin
                    drive_led(1'b0, 1'b0, 1'b0);
                    drive_tone(2400, 1'b1);
                end
                else if (c >= 30)
                    go_dark();
            end
            MS_GND_LOCK:
            begin
                if (in_span(c, 9, 16))
                begin
                    drive_led(1'b0, 1'b0, 1'b0);
                    drive_tone(3400, 1'b1);
                end
                else if (in_span(c, 15, 18))
                begin
                    drive_led(1'b0, 1'b1, 1'b0);
                    drive_tone(3200, 1'b1);
                end
                else if (in_span(c, 17, 20))
                begin
                    drive_led(1'b1, 1'b1, 1'b1);
                    drive_tone(3600, 1'b1);
                end
                else if (c >= 20)
                    go_dark();
            end
            MS_PAD_IDLE:
            begin
                if (in_span(c, 9, 16))
                begin
                    drive_tone(1800, 1'b1);
                    drive_led(1'b1, 1'b0, 1'b0);
                end
                else if (in_span(c, 16, 100))
                    go_dark();
            end
            MS_CHUTE:
            begin
                if (in_span(c, 4, 11))
                begin
                    drive_tone(2800, 1'b1);
                    drive_led(1'b1, 1'b1, 1'b0);
                end
                else if (in_span(c, 9, 100))
                    go_dark();
            end
            MS_LANDED:
            begin
                if (in_span(c, 4, 20))
                begin
                    drive_tone(3000, 1'b1);
                    drive_led(1'b0, 1'b1, 1'b0);
                end
                else if (in_span(c, 19, 44))
                begin
                    drive_tone(3600, 1'b1);
                    drive_led(1'b1, 1'b0, 1'b1);
                end
                else if (c >= 43)
                    go_dark();
            end
            MS_START_FAIL:
            begin
                if (in_span(c, 9, 21))
                begin
                    drive_tone(5000, 1'b1);
                    drive_led(1'b0, 1'b1, 1'b1);
                end
                else if (in_span(c, 20, 100))
                    go_dark();
            end
            default:
            begin
            end
        endcase
    endfunction

    // Applies one item to the private state and returns the status the block should show.
    function automatic status_t advance_indicator(input logic [1:0] op,
                                                  input logic [2:0] ev,
                                                  input logic [2:0] st);
        status_t s;
        bit      drop;
        bit      placed;
        drop   = 1'b0;
        placed = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (en_ind)
                begin
                    if (pat_cnt != CNT_MAX)
                        pat_cnt = pat_cnt + 1'b1;
                    if (events_pending())
                        play_event_pattern(ev_slot[0], int'(pat_cnt));
                    else
                        play_mission_pattern(st, int'(pat_cnt));
                end
            end
            OP_ADD:
            begin
                if (ev >= EV_CMD && ev <= EV_ERROR)
                begin
                    shift_slots();
                    for (int i = 0; i < QUEUE_SLOTS; i++)
                    begin
                        if (!placed && ev_slot[i] == EV_NONE)
                        begin
                            // An event that lands at the head starts its pattern afresh.
                            if (i == 0)
                                pat_cnt = '0;
                            ev_slot[i] = ev;
                            placed     = 1'b1;
                        end
                    end
                    drop = !placed;
                end
            end
            OP_START_END:
                startup_seen = 1'b1;
            default:
            begin
            end
        endcase
        s.red     = led_lvl[2];
        s.green   = led_lvl[1];
        s.blue    = led_lvl[0];
        s.tone_on = tone_live;
        s.hz      = tone_hz;
        s.head    = ev_slot[0];
        s.dropped = drop;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Idle length in cycles: usually none or a few, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Presents one item and waits for its transfer. The valid is left high on return,
    // so that the next item can follow without a gap. The caller lowers it through
    // settle() before anything other than another item.
    task automatic send_item(input logic [1:0] op, input logic [2:0] ev, input logic [2:0] st);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        event_code    <= ev;
        mission_state <= st;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_status.push_back(advance_indicator(op, ev, st));
    endtask

    // The event code is unused by a tick, so it carries random bits.
    task automatic tick(input logic [2:0] st);
        send_item(OP_TICK, 3'($urandom_range(0, 7)), st);
    endtask

    task automatic add_event(input logic [2:0] ev);
        send_item(OP_ADD, ev, 3'($urandom_range(0, 7)));
    endtask

    function automatic logic [2:0] any_event();
        return 3'($urandom_range(EV_CMD, EV_ERROR));
    endfunction

    function automatic logic [2:0] any_state();
        return 3'($urandom_range(0, 7));
    endfunction

    // Off-script traffic: valid adds, bad event codes, the unused opcode and the startup mark.
    task automatic send_noise();
        logic [2:0] bad;
        bad = ($urandom_range(0, 3) == 0) ? EV_NONE : 3'($urandom_range(EV_BAD_MIN, EV_BAD_MAX));
        case ($urandom_range(0, 3))
            0: add_event(any_event());
            1: add_event(bad);
            2: send_item(OP_UNUSED, 3'($urandom_range(0, 7)), any_state());
            default: send_item(OP_START_END, 3'($urandom_range(0, 7)), any_state());
        endcase
    endtask

    // Ticks until every queued event has played out, as long as the indicator is enabled.
    task automatic drain_queue();
        while (en_ind && !queue_empty())
            tick(any_state());
    endtask

    // Stops offering items and waits until every owed result has been taken,
    // or until a limit on the wait runs out.
    task automatic settle();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (pending_status.size() != 0 && n < 5000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (3) @(posedge clk);
    endtask

    // Writes all three enables back to back and mirrors each register write
    // in the private copy once its transfer has happened.
    task automatic write_enables(input bit ind, input bit buz, input bit led);
        logic [1:0] idx [3];
        bit         val [3];
        idx = '{CFG_INDICATOR_EN, CFG_BUZZER_EN, CFG_LED_EN};
        val = '{ind, buz, led};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[i])
                CFG_INDICATOR_EN: en_ind = val[i];
                CFG_BUZZER_EN:    en_buz = val[i];
                CFG_LED_EN:       en_led = val[i];
                default:
                begin
                end
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Prints one line per failure and counts it.
    task automatic report_error(input string msg);
        mismatches++;
        $display("ERROR %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [12:0] got,
                               input logic [12:0] want);
        if (got !== want)
            report_error($sformatf("%s is %0d, should be %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Result side: back-pressure and checking
    // ------------------------------------------------------------------------

    // The result channel accepts for a stretch and then stalls for a while.
    initial
    begin
        int run;
        int stall;
        forever
        begin
            out_ready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Every result transfer is matched against the oldest owed status.
    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status.size() == 0)
                report_error("result transfer with no item waiting for it");
            else
            begin
                want = pending_status.pop_front();
                check_field("led_red", 13'(led_red), 13'(want.red));
                check_field("led_green", 13'(led_green), 13'(want.green));
                check_field("led_blue", 13'(led_blue), 13'(want.blue));
                check_field("buzzer_on", 13'(buzzer_on), 13'(want.tone_on));
                check_field("buzzer_freq", buzzer_freq, want.hz);
                check_field("head_event", 13'(head_event), 13'(want.head));
                check_field("event_dropped", 13'(event_dropped), 13'(want.dropped));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Directed opening: the unused opcode, ignored event codes, filling the queue
    // until an add is dropped, one complete command pattern, and then a second
    // drop once the queue has moved up.
    task automatic test_directed();
        send_item(OP_UNUSED, EV_BAD_MAX, MS_NONE);
        tick(MS_NONE);
        add_event(EV_NONE);
        add_event(EV_BAD_MIN);
        add_event(EV_BAD_MAX);
        add_event(EV_CMD);
        add_event(EV_USB);
        add_event(EV_ABORT);
        add_event(EV_ERROR);
        repeat (12) tick(any_state());
        add_event(EV_ERROR);
        add_event(EV_CMD);
    endtask

    // The queued events play out first, which leaves the counter at zero. The startup
    // pattern then runs through every window up to its own end. The startup mark and
    // one more startup tick follow, and that tick must show nothing new.
    task automatic test_startup_pattern();
        drain_queue();
        repeat (31) tick(MS_STARTUP);
        send_item(OP_START_END, any_event(), any_state());
        tick(MS_STARTUP);
    endtask

    // Well-formed event bursts with random content. Stray items land while the
    // patterns are playing.
    task automatic test_event_patterns();
        int n;
        for (int round = 0; round < 4; round++)
        begin
            quiet = (round == 2);
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    add_event(any_event());
            end
            while (!queue_empty())
            begin
                if ($urandom_range(0, 19) == 0)
                    send_noise();
                else
                    tick(any_state());
            end
        end
        quiet = 1'b0;
    endtask

    // With no mission pattern selected, the counter runs into its ceiling of 255.
    // States whose windows all lie below the counter then play nothing. Nav start
    // finally clears the counter through its end-of-pattern branch.
    task automatic test_counter_saturation();
        drain_queue();
        quiet = ($urandom_range(0, 1) == 1);
        repeat (258) tick(MS_NONE);
        tick(MS_PAD_IDLE);
        tick(MS_CHUTE);
        tick(MS_START_FAIL);
        tick(MS_STARTUP);
        tick(MS_NAV_START);
        tick(MS_GND_LOCK);
        quiet = 1'b0;
    endtask

    // Each mission state in turn. A short abort event first brings the counter back
    // near zero, so that the early windows are reached.
    task automatic test_mission_patterns();
        int len;
        for (int s = 0; s < 8; s++)
        begin
            if (pat_cnt > 3)
            begin
                add_event(EV_ABORT);
                drain_queue();
            end
            quiet = (s == 5);
            len = $urandom_range(10, 46);
            repeat (len)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_noise();
                else
                    tick(3'(s));
            end
        end
        quiet = 1'b0;
        drain_queue();
    endtask

    // Every combination of the three enables, all off and all on among them.
    // Registers change only while nothing is in flight.
    task automatic test_enables();
        for (int k = 0; k < 8; k++)
        begin
            settle();
            write_enables(k[0], k[1], k[2]);
            repeat (16)
            begin
                if ($urandom_range(0, 5) == 0)
                    add_event(any_event());
                else
                    tick(any_state());
            end
        end
        settle();
        write_enables(1'b1, 1'b1, 1'b1);
        drain_queue();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        opcode        <= OP_TICK;
        event_code    <= EV_NONE;
        mission_state <= MS_STARTUP;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_INDICATOR_EN;
        cfg_data      <= 1'b0;
        reset_indicator();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_startup_pattern();
        test_event_patterns();
        test_counter_saturation();
        test_mission_patterns();
        test_enables();

        // Let the last results drain, then settle the verdict.
        settle();
        if (pending_status.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_status.size()));
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
